// ===== hw/rtl/mwsm_pkg.sv =====
package mwsm_pkg;

	localparam int NUM_WHEELS = 4;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_AXIS_INVERT     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WHEEL_REVERSE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_WHEEL_RADIUS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HALF_BASE_SUM   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_WHEEL_SPEED = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_BAND       = 3'd5;

	// command axis after optional negation
	localparam int AXIS_W = 17;
	// linear sum or difference of two axes
	localparam int LIN_W  = 18;
	// mixed wheel term in units of 2^-16
	localparam int MIX_W  = 34;
	// gained wheel term in units of 2^-24
	localparam int PROD_W = 51;
	// rounded magnitude, unsigned Q27.8
	localparam int MAG_W  = 35;
	localparam int FRAC_DROP = 16;

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

	typedef struct packed {
		logic [2:0]  axis_invert;
		logic [3:0]  wheel_reverse;
		logic [15:0] inv_wheel_radius;
		logic [15:0] half_base_sum;
		logic [14:0] max_wheel_speed;
		logic [14:0] zero_band;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		axis_invert:      3'd0,
		wheel_reverse:    4'd0,
		inv_wheel_radius: 16'd256,
		half_base_sum:    16'd128,
		max_wheel_speed:  15'd32767,
		zero_band:        15'd0
	};

	typedef logic signed [MIX_W-1:0] mix_t;

endpackage

// ===== hw/rtl/mwsm_cfg.sv =====
module mwsm_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mwsm_pkg::ADDR_W-1:0]  paddr,
	input  logic [mwsm_pkg::DATA_W-1:0]  pwdata,
	output logic [mwsm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output mwsm_pkg::cfg_t               cfg
);

	mwsm_pkg::cfg_t                    cfg_q;
	logic [mwsm_pkg::REG_IDX_W-1:0]    idx;
	logic                              wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[mwsm_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mwsm_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				mwsm_pkg::REG_AXIS_INVERT:      cfg_q.axis_invert      <= pwdata[2:0];
				mwsm_pkg::REG_WHEEL_REVERSE:    cfg_q.wheel_reverse    <= pwdata[3:0];
				mwsm_pkg::REG_INV_WHEEL_RADIUS: cfg_q.inv_wheel_radius <= pwdata[15:0];
				mwsm_pkg::REG_HALF_BASE_SUM:    cfg_q.half_base_sum    <= pwdata[15:0];
				mwsm_pkg::REG_MAX_WHEEL_SPEED:  cfg_q.max_wheel_speed  <= pwdata[14:0];
				mwsm_pkg::REG_ZERO_BAND:        cfg_q.zero_band        <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mwsm_pkg::REG_AXIS_INVERT:      prdata = 32'(cfg_q.axis_invert);
			mwsm_pkg::REG_WHEEL_REVERSE:    prdata = 32'(cfg_q.wheel_reverse);
			mwsm_pkg::REG_INV_WHEEL_RADIUS: prdata = 32'(cfg_q.inv_wheel_radius);
			mwsm_pkg::REG_HALF_BASE_SUM:    prdata = 32'(cfg_q.half_base_sum);
			mwsm_pkg::REG_MAX_WHEEL_SPEED:  prdata = 32'(cfg_q.max_wheel_speed);
			mwsm_pkg::REG_ZERO_BAND:        prdata = 32'(cfg_q.zero_band);
			default:                        prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/mwsm_mix.sv =====
module mwsm_mix (
	input  logic                clk,
	input  logic                en,
	input  mwsm_pkg::cfg_t      cfg,
	input  logic signed [15:0]  fwd,
	input  logic signed [15:0]  side,
	input  logic signed [15:0]  turn,
	output mwsm_pkg::mix_t      mix_s2 [mwsm_pkg::NUM_WHEELS]
);

	logic signed [mwsm_pkg::AXIS_W-1:0] vx, vy, wz;
	logic signed [mwsm_pkg::AXIS_W-1:0] fwd_x, side_x, turn_x;
	logic signed [mwsm_pkg::LIN_W-1:0]  lin_sum_c, lin_diff_c;
	logic signed [mwsm_pkg::MIX_W-1:0]  turn_c;
	logic signed [mwsm_pkg::LIN_W-1:0]  lin_sum_s1, lin_diff_s1;
	logic signed [mwsm_pkg::MIX_W-1:0]  turn_s1;
	mwsm_pkg::mix_t                     lsum, ldiff;

	assign fwd_x  = $signed({fwd[15], fwd});
	assign side_x = $signed({side[15], side});
	assign turn_x = $signed({turn[15], turn});

	assign vx = cfg.axis_invert[0] ? -fwd_x  : fwd_x;
	assign vy = cfg.axis_invert[1] ? -side_x : side_x;
	assign wz = cfg.axis_invert[2] ? -turn_x : turn_x;

	assign lin_sum_c  = $signed({vx[16], vx}) + $signed({vy[16], vy});
	assign lin_diff_c = $signed({vx[16], vx}) - $signed({vy[16], vy});
	assign turn_c     = $signed({1'b0, cfg.half_base_sum}) * wz;

	always_ff @(posedge clk) begin
		if (en) begin
			lin_sum_s1  <= lin_sum_c;
			lin_diff_s1 <= lin_diff_c;
			turn_s1     <= turn_c;
		end
	end

	// linear terms scaled to units of 2^-16
	assign lsum  = $signed({{8{lin_sum_s1[17]}}, lin_sum_s1, 8'b0});
	assign ldiff = $signed({{8{lin_diff_s1[17]}}, lin_diff_s1, 8'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			mix_s2[0] <= ldiff - turn_s1;
			mix_s2[1] <= lsum + turn_s1;
			mix_s2[2] <= lsum - turn_s1;
			mix_s2[3] <= ldiff + turn_s1;
		end
	end

endmodule

// ===== hw/rtl/mwsm_wheel.sv =====
module mwsm_wheel (
	input  logic                clk,
	input  logic                en,
	input  mwsm_pkg::mix_t      mix_s2,
	input  logic [15:0]         gain,
	input  logic                rev,
	input  logic [14:0]         max_speed,
	input  logic [14:0]         zero_band,
	output logic signed [15:0]  speed_s5,
	output logic                clip_s5
);

	logic signed [mwsm_pkg::PROD_W-1:0] prod_c, prod_s3;
	logic [mwsm_pkg::PROD_W-1:0]        abs_c, rnd_c;
	logic [mwsm_pkg::MAG_W-1:0]         mag_s4;
	logic                               neg_s4;
	logic                               clip_c;
	logic [14:0]                        lim_c, band_c;
	logic signed [15:0]                 speed_c;

	assign prod_c = mix_s2 * $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_c;
		end
	end

	// round magnitude to nearest, ties away from zero
	assign abs_c = prod_s3[mwsm_pkg::PROD_W-1] ? unsigned'(-prod_s3) : unsigned'(prod_s3);
	assign rnd_c = abs_c + mwsm_pkg::ROUND_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4 <= rnd_c[mwsm_pkg::PROD_W-1:mwsm_pkg::FRAC_DROP];
			neg_s4 <= prod_s3[mwsm_pkg::PROD_W-1] ^ rev;
		end
	end

	assign clip_c  = mag_s4 > mwsm_pkg::MAG_W'(max_speed);
	assign lim_c   = clip_c ? max_speed : mag_s4[14:0];
	assign band_c  = (lim_c != '0 && lim_c < zero_band) ? '0 : lim_c;
	assign speed_c = neg_s4 ? -$signed({1'b0, band_c}) : $signed({1'b0, band_c});

	always_ff @(posedge clk) begin
		if (en) begin
			speed_s5 <= speed_c;
			clip_s5  <= clip_c;
		end
	end

endmodule

// ===== hw/rtl/mecanum_wheel_speed_mixer_unit.sv =====
// Mecanum wheel speed mixer: turns one body velocity command (forward, side,
// turn rate, signed Q8.8) into four wheel speeds plus per-wheel clip flags.
// Command channel: cmd_valid / cmd_stall with forward_speed, side_speed,
// turn_rate. A word is taken at a clock edge with cmd_valid high and
// cmd_stall low. Result channel: wheel_valid / wheel_stall with wheel_one ..
// wheel_four and clip_flags, taken the same way.
// An accepted command passes through the five-stage pipe (axis sums and turn
// product, wheel mix, gain multiply, rounding, limits) to its result word on
// the outputs; a new command is taken every cycle while cmd_stall is low.
// When the receiver stalls a valid result, the whole pipe holds and
// cmd_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (arst_n low) empties the pipe and loads the register defaults:
// no inversion, no reversal, gain 1.0, k 0.5, limit 32767, no zero band.
// Registers sit on an APB-style port at byte address 4*i and should only be
// written while no command is in flight.
module mecanum_wheel_speed_mixer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mwsm_pkg::ADDR_W-1:0]  paddr,
	input  logic [mwsm_pkg::DATA_W-1:0]  pwdata,
	output logic [mwsm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic signed [15:0]           forward_speed,
	input  logic signed [15:0]           side_speed,
	input  logic signed [15:0]           turn_rate,
	output logic                         wheel_valid,
	input  logic                         wheel_stall,
	output logic signed [15:0]           wheel_one,
	output logic signed [15:0]           wheel_two,
	output logic signed [15:0]           wheel_three,
	output logic signed [15:0]           wheel_four,
	output logic [3:0]                   clip_flags
);

	mwsm_pkg::cfg_t      cfg;
	logic                adv;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	mwsm_pkg::mix_t      mix_s2 [mwsm_pkg::NUM_WHEELS];
	logic signed [15:0]  speed_s5 [mwsm_pkg::NUM_WHEELS];
	logic [mwsm_pkg::NUM_WHEELS-1:0] clip_s5;

	mwsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipe moves unless a finished word is held by the receiver
	assign adv       = !(v_s5 && wheel_stall);
	assign cmd_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	mwsm_mix u_mix (
		.clk    (clk),
		.en     (adv),
		.cfg    (cfg),
		.fwd    (forward_speed),
		.side   (side_speed),
		.turn   (turn_rate),
		.mix_s2 (mix_s2)
	);

	for (genvar i = 0; i < mwsm_pkg::NUM_WHEELS; i++) begin : g_wheel
		mwsm_wheel u_wheel (
			.clk       (clk),
			.en        (adv),
			.mix_s2    (mix_s2[i]),
			.gain      (cfg.inv_wheel_radius),
			.rev       (cfg.wheel_reverse[i]),
			.max_speed (cfg.max_wheel_speed),
			.zero_band (cfg.zero_band),
			.speed_s5  (speed_s5[i]),
			.clip_s5   (clip_s5[i])
		);
	end

	assign wheel_valid = v_s5;
	assign wheel_one   = speed_s5[0];
	assign wheel_two   = speed_s5[1];
	assign wheel_three = speed_s5[2];
	assign wheel_four  = speed_s5[3];
	assign clip_flags  = clip_s5;

	a_stall_only_on_blocked_out: assert property (
		@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (wheel_valid && wheel_stall)
	) else $error("command stalled while result side free");

	a_pipe_holds_on_stall: assert property (
		@(posedge clk) disable iff (!arst_n)
		!adv |=> ({v_s1, v_s2, v_s3, v_s4, v_s5} == $past({v_s1, v_s2, v_s3, v_s4, v_s5}))
	) else $error("valid bits moved during stall");

	a_word_reaches_out: assert property (
		@(posedge clk) disable iff (!arst_n)
		(adv && v_s4) |=> wheel_valid
	) else $error("word lost before result register");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int PIPE_LAT = 8;
	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 56;
	localparam int IDLE_PCT = 15;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [mwsm_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd6;

	typedef enum logic { ROW_CMD, ROW_CFG } row_kind_t;

	typedef struct packed {
		logic signed [15:0] one;
		logic signed [15:0] two;
		logic signed [15:0] three;
		logic signed [15:0] four;
		logic [3:0]         clip;
	} wheel_word_t;

	typedef struct {
		row_kind_t                          kind;
		logic [mwsm_pkg::REG_IDX_W-1:0]     idx;
		logic [31:0]                        value;
		logic signed [15:0]                 fx;
		logic signed [15:0]                 sx;
		logic signed [15:0]                 tz;
		bit                                 typed;
		wheel_word_t                        want;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mwsm_pkg::ADDR_W-1:0]    paddr;
	logic [mwsm_pkg::DATA_W-1:0]    pwdata;
	logic [mwsm_pkg::DATA_W-1:0]    prdata;
	logic                           pready;
	logic                           cmd_valid;
	logic                           cmd_stall;
	logic signed [15:0]             forward_speed;
	logic signed [15:0]             side_speed;
	logic signed [15:0]             turn_rate;
	logic                           wheel_valid;
	logic                           wheel_stall;
	logic signed [15:0]             wheel_one;
	logic signed [15:0]             wheel_two;
	logic signed [15:0]             wheel_three;
	logic signed [15:0]             wheel_four;
	logic [3:0]                     clip_flags;

	mwsm_pkg::cfg_t shadow_cfg;
	wheel_word_t    wheels_due [$];
	stim_row_t      stim_rows [$];
	wheel_word_t    got_word;
	int             mismatches;
	int             cycle_cnt;
	bit             quiet;

	mecanum_wheel_speed_mixer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.forward_speed (forward_speed),
		.side_speed    (side_speed),
		.turn_rate     (turn_rate),
		.wheel_valid   (wheel_valid),
		.wheel_stall   (wheel_stall),
		.wheel_one     (wheel_one),
		.wheel_two     (wheel_two),
		.wheel_three   (wheel_three),
		.wheel_four    (wheel_four),
		.clip_flags    (clip_flags)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic wheel_word_t mix_wheels(input mwsm_pkg::cfg_t c,
			input logic signed [15:0] fx, input logic signed [15:0] sx,
			input logic signed [15:0] tz);
		longint vx, vy, wz, k, g, lim, band, lin_d, lin_s, turn, p, mag;
		longint mix [4];
		logic signed [15:0] spd [4];
		logic [3:0] clip;
		bit neg;
		int i;
		wheel_word_t r;
		vx = fx;
		vy = sx;
		wz = tz;
		k = c.half_base_sum;
		g = c.inv_wheel_radius;
		lim = c.max_wheel_speed;
		band = c.zero_band;
		if (c.axis_invert[0]) vx = -vx;
		if (c.axis_invert[1]) vy = -vy;
		if (c.axis_invert[2]) wz = -wz;
		lin_d = (vx - vy) * 256;
		lin_s = (vx + vy) * 256;
		turn = k * wz;
		mix[0] = lin_d - turn;
		mix[1] = lin_s + turn;
		mix[2] = lin_s - turn;
		mix[3] = lin_d + turn;
		clip = '0;
		for (i = 0; i < mwsm_pkg::NUM_WHEELS; i++) begin
			p = mix[i] * g;
			if (c.wheel_reverse[i]) p = -p;
			neg = p < 0;
			mag = ((neg ? -p : p) + 32768) >>> 16;
			if (mag > lim) begin
				mag = lim;
				clip[i] = 1'b1;
			end
			if (mag != 0 && mag < band) mag = 0;
			spd[i] = 16'(neg ? -mag : mag);
		end
		r.one = spd[0];
		r.two = spd[1];
		r.three = spd[2];
		r.four = spd[3];
		r.clip = clip;
		return r;
	endfunction

	function automatic int pick_reg(input int top, input int span);
		if ($urandom_range(3) == 0) return $urandom_range(1) ? top : 0;
		return $urandom_range(span);
	endfunction

	function automatic logic signed [15:0] rand_speed();
		case ($urandom_range(9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3, 4: return 16'($signed($urandom_range(1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_cfg(input logic [mwsm_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.value = value;
		r.typed = 1'b0;
		stim_rows.push_back(r);
	endtask

	task automatic add_cmd(input logic signed [15:0] fx, input logic signed [15:0] sx,
			input logic signed [15:0] tz);
		stim_row_t r;
		r.kind = ROW_CMD;
		r.fx = fx;
		r.sx = sx;
		r.tz = tz;
		r.typed = 1'b0;
		stim_rows.push_back(r);
	endtask

	task automatic add_chk(input logic signed [15:0] fx, input logic signed [15:0] sx,
			input logic signed [15:0] tz, input logic signed [15:0] w1,
			input logic signed [15:0] w2, input logic signed [15:0] w3,
			input logic signed [15:0] w4, input logic [3:0] clip);
		stim_row_t r;
		r.kind = ROW_CMD;
		r.fx = fx;
		r.sx = sx;
		r.tz = tz;
		r.typed = 1'b1;
		r.want.one = w1;
		r.want.two = w2;
		r.want.three = w3;
		r.want.four = w4;
		r.want.clip = clip;
		stim_rows.push_back(r);
	endtask

	task automatic reg_write(input logic [mwsm_pkg::REG_IDX_W-1:0] idx,
			input logic [31:0] value);
		bit rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			mwsm_pkg::REG_AXIS_INVERT:      shadow_cfg.axis_invert = value[2:0];
			mwsm_pkg::REG_WHEEL_REVERSE:    shadow_cfg.wheel_reverse = value[3:0];
			mwsm_pkg::REG_INV_WHEEL_RADIUS: shadow_cfg.inv_wheel_radius = value[15:0];
			mwsm_pkg::REG_HALF_BASE_SUM:    shadow_cfg.half_base_sum = value[15:0];
			mwsm_pkg::REG_MAX_WHEEL_SPEED:  shadow_cfg.max_wheel_speed = value[14:0];
			mwsm_pkg::REG_ZERO_BAND:        shadow_cfg.zero_band = value[14:0];
			default: ;
		endcase
	endtask

	task automatic send_cmd(input logic signed [15:0] fx, input logic signed [15:0] sx,
			input logic signed [15:0] tz, input bit typed, input wheel_word_t want);
		bit acc;
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		forward_speed <= fx;
		side_speed <= sx;
		turn_rate <= tz;
		do begin
			@(negedge clk);
			acc = !cmd_stall;
			@(posedge clk);
		end while (!acc);
		wheels_due.push_back(typed ? want : mix_wheels(shadow_cfg, fx, sx, tz));
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (wheels_due.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		wheel_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// word is taken at the next rising edge, outputs are stable here
	always @(negedge clk) begin
		if (arst_n && wheel_valid && !wheel_stall) begin
			if (wheels_due.size() == 0) begin
				$display("%0t unexpected word expected none actual %0d %0d %0d %0d %h",
					$time, wheel_one, wheel_two, wheel_three, wheel_four, clip_flags);
				mismatches++;
			end else begin
				got_word = wheels_due.pop_front();
				check_field("wheel_one", int'(got_word.one), int'(wheel_one));
				check_field("wheel_two", int'(got_word.two), int'(wheel_two));
				check_field("wheel_three", int'(got_word.three), int'(wheel_three));
				check_field("wheel_four", int'(got_word.four), int'(wheel_four));
				check_field("clip_flags", int'(got_word.clip), int'(clip_flags));
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int phase, n;
		mwsm_pkg::cfg_t c;
		stim_row_t r;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_valid = 1'b0;
		forward_speed = '0;
		side_speed = '0;
		turn_rate = '0;
		wheel_stall = 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		shadow_cfg = mwsm_pkg::CFG_RESET;

		// defaults after reset: gain 1.0, k 0.5
		add_chk(0, 0, 0, 0, 0, 0, 0, 4'h0);
		add_chk(256, 0, 0, 256, 256, 256, 256, 4'h0);
		add_chk(0, 256, 0, -256, 256, 256, -256, 4'h0);
		add_chk(0, 0, 256, -128, 128, -128, 128, 4'h0);
		// half lsb ties round away from zero
		add_chk(0, 0, 1, -1, 1, -1, 1, 4'h0);
		add_chk(0, 0, -1, 1, -1, 1, -1, 4'h0);
		add_chk(32767, 0, 0, 32767, 32767, 32767, 32767, 4'h0);
		add_chk(-32768, 0, 0, -32767, -32767, -32767, -32767, 4'hF);
		add_chk(32767, 32767, 0, 0, 32767, 32767, 0, 4'h6);
		add_chk(-32768, -32768, -32768, 16384, -32767, -32767, -16384, 4'h6);
		// value at the limit is not clipped
		add_cfg(mwsm_pkg::REG_MAX_WHEEL_SPEED, 256);
		add_chk(256, 0, 0, 256, 256, 256, 256, 4'h0);
		add_chk(257, 0, 0, 256, 256, 256, 256, 4'hF);
		add_cfg(mwsm_pkg::REG_INV_WHEEL_RADIUS, 255);
		add_cmd(257, 0, 0);
		// clipped value inside the zero band
		add_cfg(mwsm_pkg::REG_INV_WHEEL_RADIUS, 256);
		add_cfg(mwsm_pkg::REG_MAX_WHEEL_SPEED, 100);
		add_cfg(mwsm_pkg::REG_ZERO_BAND, 300);
		add_chk(256, 0, 0, 0, 0, 0, 0, 4'hF);
		add_cfg(mwsm_pkg::REG_MAX_WHEEL_SPEED, 32767);
		add_chk(256, 0, 0, 0, 0, 0, 0, 4'h0);
		add_chk(-256, 0, 0, 0, 0, 0, 0, 4'h0);
		add_chk(300, 0, 0, 300, 300, 300, 300, 4'h0);
		add_cfg(mwsm_pkg::REG_ZERO_BAND, 0);
		add_cfg(mwsm_pkg::REG_AXIS_INVERT, 7);
		add_cmd(256, 512, -768);
		add_cfg(mwsm_pkg::REG_AXIS_INVERT, 0);
		add_cfg(mwsm_pkg::REG_WHEEL_REVERSE, 4'b0101);
		add_cmd(256, 512, -768);
		add_cfg(mwsm_pkg::REG_WHEEL_REVERSE, 0);
		add_cfg(mwsm_pkg::REG_HALF_BASE_SUM, 16'hFFFF);
		add_cfg(mwsm_pkg::REG_INV_WHEEL_RADIUS, 16'hFFFF);
		add_cmd(32767, -32768, 32767);
		add_cmd(1, 1, 1);
		add_cfg(mwsm_pkg::REG_INV_WHEEL_RADIUS, 0);
		add_chk(32767, 32767, 32767, 0, 0, 0, 0, 4'h0);
		// unmapped index must change nothing
		add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
		add_cfg(mwsm_pkg::REG_INV_WHEEL_RADIUS, 256);
		add_cfg(mwsm_pkg::REG_HALF_BASE_SUM, 0);
		add_cfg(mwsm_pkg::REG_MAX_WHEEL_SPEED, 0);
		add_chk(256, 0, 0, 0, 0, 0, 0, 4'hF);
		add_chk(0, 0, 32767, 0, 0, 0, 0, 4'h0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[j]) begin
			r = stim_rows[j];
			if (r.kind == ROW_CFG) begin
				drain();
				reg_write(r.idx, r.value);
			end else begin
				send_cmd(r.fx, r.sx, r.tz, r.typed, r.want);
			end
		end

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			quiet = (phase == 3);
			case (phase)
				0: c = mwsm_pkg::CFG_RESET;
				1: c = '{3'h7, 4'hF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF};
				default: begin
					c.axis_invert = 3'($urandom);
					c.wheel_reverse = 4'($urandom);
					c.inv_wheel_radius = 16'(pick_reg(65535, 1023));
					c.half_base_sum = 16'(pick_reg(65535, 1023));
					c.max_wheel_speed = 15'(pick_reg(32767, 32767));
					c.zero_band = 15'(pick_reg(32767, 512));
				end
			endcase
			// upper bits of each word carry junk
			reg_write(mwsm_pkg::REG_AXIS_INVERT, 32'({$urandom, c.axis_invert}));
			reg_write(mwsm_pkg::REG_WHEEL_REVERSE, 32'({$urandom, c.wheel_reverse}));
			reg_write(mwsm_pkg::REG_INV_WHEEL_RADIUS, 32'({$urandom, c.inv_wheel_radius}));
			reg_write(mwsm_pkg::REG_HALF_BASE_SUM, 32'({$urandom, c.half_base_sum}));
			reg_write(mwsm_pkg::REG_MAX_WHEEL_SPEED,
				32'({$urandom, 1'b0, c.max_wheel_speed}));
			reg_write(mwsm_pkg::REG_ZERO_BAND, 32'({$urandom, 1'b1, c.zero_band}));
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 4 && n == ITEMS_PER_PHASE / 2) drain();
				send_cmd(rand_speed(), rand_speed(), rand_speed(), 1'b0, '0);
			end
		end

		drain();
		if (mismatches == 0 && wheels_due.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mwsm_pkg.sv
hw/rtl/mwsm_cfg.sv
hw/rtl/mwsm_mix.sv
hw/rtl/mwsm_wheel.sv
hw/rtl/mecanum_wheel_speed_mixer_unit.sv
test/tb.sv
